[rtl/point_light_pixel_shader_macros.svh]
// ----------------------------------------------------------------------------
// Point light pixel shader assertion macros
// Concurrent assertion helpers used by the shader controller.
// ----------------------------------------------------------------------------
`ifndef POINT_LIGHT_PIXEL_SHADER_MACROS_SVH
`define POINT_LIGHT_PIXEL_SHADER_MACROS_SVH
`ifndef SYNTHESIS
`define PLPS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLPS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PLPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLPS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[rtl/plps_pkg.sv]
// ----------------------------------------------------------------------------
// Point light pixel shader package
// Shared constants, state codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package plps_pkg;
	localparam int LIGHT_SLOTS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int SLOT_W      = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
	localparam int CNT_W       = $clog2(LIGHT_SLOTS + 1);
	localparam int PROD_W      = 33;
	localparam int P_W         = PROD_W - FRAC_BITS + 1;
	localparam int L_W         = P_W + 1;
	localparam int SQ_W        = 2 * L_W;
	localparam int M2_W        = SQ_W + 2;
	localparam int NL_W        = 16 + L_W;
	localparam int DOT_W       = NL_W + 2;
	localparam int NUM_W       = 16 + 2 * FRAC_BITS;
	localparam int DIVCNT_W    = $clog2(NUM_W);
	localparam int F_W         = 32;
	localparam int CON_W       = F_W + 17;
	localparam int ACC_W       = CON_W + CNT_W + 2;

	localparam logic [1:0] CFG_AMBIENT = 2'd0;
	localparam logic [1:0] CFG_COUNT   = 2'd1;
	localparam logic [1:0] CFG_MISS    = 2'd2;

	localparam logic [1:0] FLD_POS   = 2'd0;
	localparam logic [1:0] FLD_COLOR = 2'd1;
	localparam logic [1:0] FLD_RANGE = 2'd2;
	localparam logic [1:0] FLD_INT   = 2'd3;

	localparam logic [47:0] MISS_RESET = 48'h001A_0052_0052;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HIT, ST_FETCH, ST_SQ, ST_SUM, ST_TEST,
		ST_DIV, ST_MUL, ST_ACC, ST_FINISH
	} state_t;

	typedef struct packed {
		logic             capture;
		logic             wr_light;
		logic             hit_calc;
		logic             fetch;
		logic             square;
		logic             sum;
		logic             div_start;
		logic             div_step;
		logic             set_cap;
		logic             mul;
		logic             acc;
		logic             load_out;
		logic [SLOT_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic pass;
		logic m2_zero;
		logic div_done;
		logic out_busy;
	} stat_t;
endpackage

[rtl/plps_dp.sv]
// ----------------------------------------------------------------------------
// Point light pixel shader datapath
// Light table, hit point, distance tests, serial divider, color accumulators
// and the output register.
// ----------------------------------------------------------------------------
module plps_dp import plps_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output stat_t        st,
	input  logic [214:0] in_data,
	input  logic [47:0]  ambient_color,
	input  logic [47:0]  miss_color,
	output logic [47:0]  out_data,
	output logic         out_hit,
	output logic         out_valid,
	input  logic         out_ready
);
	logic [47:0] pos_tab [LIGHT_SLOTS];
	logic [47:0] col_tab [LIGHT_SLOTS];
	logic [15:0] rng_tab [LIGHT_SLOTS];
	logic [15:0] int_tab [LIGHT_SLOTS];

	logic              hit_q;
	logic [47:0]       org_q, dir_q, nrm_q;
	logic [15:0]       dist_q;
	logic signed [P_W-1:0]   p_q   [3];
	logic signed [L_W-1:0]   l_q   [3];
	logic [47:0]       col_q;
	logic [15:0]       rng_q, int_q;
	logic signed [SQ_W-1:0]  sq_q  [3];
	logic signed [NL_W-1:0]  nl_q  [3];
	logic [31:0]       rr_q;
	logic [M2_W-1:0]   m2_q;
	logic              pass_q, zero_q, cap_q;
	logic [32:0]       rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [DIVCNT_W-1:0] dcnt_q;
	logic signed [CON_W-1:0] prod_q [3];
	logic signed [ACC_W-1:0] acc_q  [3];
	logic [47:0]       out_q;
	logic              out_hit_q, out_valid_q;

	logic [3:0]        w_slot;
	logic [1:0]        w_field;
	logic [47:0]       w_value;
	logic [SLOT_W-1:0] w_idx;
	logic signed [M2_W-1:0]  m2_sum;
	logic signed [DOT_W-1:0] dot_sum;
	logic [32:0]       trial;
	logic [63:0]       numx;
	logic [F_W-1:0]    f_val;

	assign w_slot  = in_data[164:161];
	assign w_field = in_data[166:165];
	assign w_value = in_data[214:167];
	assign w_idx   = SLOT_W'(w_slot);

	always_ff @(posedge clk) begin
		if (cmd.wr_light && (int'(w_slot) < LIGHT_SLOTS)) begin
			case (w_field)
				FLD_POS:   pos_tab[w_idx] <= w_value;
				FLD_COLOR: col_tab[w_idx] <= w_value;
				FLD_RANGE: rng_tab[w_idx] <= w_value[15:0];
				FLD_INT:   int_tab[w_idx] <= w_value[15:0];
				default:   int_tab[w_idx] <= w_value[15:0];
			endcase
		end
	end

	always_comb begin
		m2_sum  = M2_W'(sq_q[0]) + M2_W'(sq_q[1]) + M2_W'(sq_q[2]);
		dot_sum = DOT_W'(nl_q[0]) + DOT_W'(nl_q[1]) + DOT_W'(nl_q[2]);
		trial   = {rem_q[31:0], num_q[NUM_W-1]};
		numx    = 64'(num_q);
		if (cap_q || numx > 64'hFFFF_FFFF)
			f_val = '1;
		else
			f_val = numx[F_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hit_q  <= in_data[0];
			org_q  <= in_data[48:1];
			dir_q  <= in_data[96:49];
			dist_q <= in_data[112:97];
			nrm_q  <= in_data[160:113];
		end
		for (int k = 0; k < 3; k++) begin
			if (cmd.hit_calc) begin
				p_q[k] <= P_W'(signed'(org_q[16*k +: 16]))
				        + P_W'((PROD_W'(signed'(dir_q[16*k +: 16]))
				        * PROD_W'(signed'({1'b0, dist_q}))) >>> FRAC_BITS);
				acc_q[k] <= ACC_W'(signed'(ambient_color[16*k +: 16]));
			end
			if (cmd.fetch)
				l_q[k] <= L_W'(signed'(pos_tab[cmd.idx][16*k +: 16])) - L_W'(p_q[k]);
			if (cmd.square) begin
				sq_q[k] <= l_q[k] * l_q[k];
				nl_q[k] <= NL_W'(signed'(nrm_q[16*k +: 16])) * NL_W'(l_q[k]);
			end
			if (cmd.mul)
				prod_q[k] <= (CON_W'(signed'({1'b0, f_val})) *
				              CON_W'(signed'(col_q[16*k +: 16]))) >>> FRAC_BITS;
			if (cmd.acc)
				acc_q[k] <= acc_q[k] + ACC_W'(prod_q[k]);
		end
		if (cmd.fetch) begin
			col_q <= col_tab[cmd.idx];
			rng_q <= rng_tab[cmd.idx];
			int_q <= int_tab[cmd.idx];
		end
		if (cmd.square)
			rr_q <= 32'(rng_q) * 32'(rng_q);
		if (cmd.sum) begin
			m2_q   <= M2_W'(m2_sum);
			pass_q <= (m2_sum <= M2_W'(rr_q)) && (dot_sum <= 0);
			zero_q <= (m2_sum == 0);
		end
		if (cmd.set_cap)
			cap_q <= 1'b1;
		if (cmd.div_start) begin
			cap_q  <= 1'b0;
			rem_q  <= '0;
			num_q  <= NUM_W'(int_q) << (2 * FRAC_BITS);
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, m2_q[31:0]}) begin
				rem_q <= trial - {1'b0, m2_q[31:0]};
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hit_q <= hit_q;
			for (int k = 0; k < 3; k++) begin
				if (!hit_q)
					out_q[16*k +: 16] <= miss_color[16*k +: 16];
				else if (acc_q[k] < 0)
					out_q[16*k +: 16] <= 16'h0000;
				else if (acc_q[k] > ACC_W'(65535))
					out_q[16*k +: 16] <= 16'hFFFF;
				else
					out_q[16*k +: 16] <= acc_q[k][15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.pass     = pass_q;
	assign st.m2_zero  = zero_q;
	assign st.div_done = (dcnt_q == DIVCNT_W'(NUM_W - 1));
	assign st.out_busy = out_valid_q && !out_ready;
	assign out_data    = out_q;
	assign out_hit     = out_hit_q;
	assign out_valid   = out_valid_q;
endmodule

[rtl/plps_ctrl.sv]
// ----------------------------------------------------------------------------
// Point light pixel shader controller
// Sequences the hit point, the per-light tests, the divider and the output.
// ----------------------------------------------------------------------------
`include "point_light_pixel_shader_macros.svh"
module plps_ctrl import plps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_mode,
	input  logic             in_hit,
	input  logic [CNT_W-1:0] n_lights,
	input  stat_t            st,
	output cmd_t             cmd
);
	state_t           state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic             take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cmd      = '0;
		cmd.idx  = idx_q[SLOT_W-1:0];
		in_ready = (state_q == ST_IDLE);
		take     = in_valid && in_ready;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					cmd.capture  = !in_mode;
					cmd.wr_light = in_mode;
					if (!in_mode)
						state_d = in_hit ? ST_HIT : ST_FINISH;
				end
			end
			ST_HIT: begin
				cmd.hit_calc = 1'b1;
				idx_d = '0;
				state_d = (n_lights == '0) ? ST_FINISH : ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.square = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				if (!st.pass) begin
					idx_d = idx_q + 1'b1;
					state_d = (idx_q + 1'b1 == n_lights) ? ST_FINISH : ST_FETCH;
				end else if (st.m2_zero) begin
					cmd.set_cap = 1'b1;
					state_d = ST_MUL;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				idx_d = idx_q + 1'b1;
				state_d = (idx_q + 1'b1 == n_lights) ? ST_FINISH : ST_FETCH;
			end
			ST_FINISH: begin
				if (!st.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`PLPS_NEVER(a_load_free, clk, arst_n, cmd.load_out && st.out_busy, "output overwritten")
	`PLPS_ASSERT(a_div_mul, clk, arst_n, (state_q == ST_DIV && st.div_done) |=> (state_q == ST_MUL), "divider did not hand off")
	`PLPS_NEVER(a_idx_range, clk, arst_n, state_q == ST_FETCH && idx_q >= n_lights, "light index past count")
endmodule

[rtl/point_light_pixel_shader.sv]
// ----------------------------------------------------------------------------
// Point light pixel shader
// Shades one traced ray per pixel beat against a table of point lights.
//
//   channel   dir  payload
//   s_axis    in   tuser mode, tdata ray or light table field
//   m_axis    out  tuser was_hit, tdata RGB
//   cfg       in   ambient_color, light_count, miss_color
//
// A light table beat is written when taken. A miss goes straight to the output;
// a hit computes the hit point, then tests each light for range and facing, and
// a lit light runs a 32-step divider (skipped at zero distance), multiply and add.
// Reset initializes control state and the config registers only; the light table
// is undefined until written. A stalled output holds the finished pixel while the
// next beat is taken.
module point_light_pixel_shader import plps_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [215:0] s_tdata,  // has_hit, ray_origin, ray_dir, hit_distance,
	                               // hit_normal, light_slot, light_field, light_value
	input  logic         s_tuser,  // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,  // pixel_red, pixel_green, pixel_blue
	output logic         m_tuser,  // was_hit
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [47:0]  cfg_wdata
);
	logic [47:0]      ambient_q, miss_q;
	logic [4:0]       count_q;
	logic [CNT_W-1:0] n_lights;
	cmd_t             cmd;
	stat_t            st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambient_q <= '0;
			count_q   <= '0;
			miss_q    <= MISS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AMBIENT: ambient_q <= cfg_wdata;
				CFG_COUNT:   count_q   <= cfg_wdata[4:0];
				CFG_MISS:    miss_q    <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	assign n_lights = (int'(count_q) > LIGHT_SLOTS) ? CNT_W'(LIGHT_SLOTS) : CNT_W'(count_q);

	plps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_mode  (s_tuser),
		.in_hit   (s_tdata[0]),
		.n_lights (n_lights),
		.st       (st),
		.cmd      (cmd)
	);

	plps_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_data       (s_tdata[214:0]),
		.ambient_color (ambient_q),
		.miss_color    (miss_q),
		.out_data      (m_tdata),
		.out_hit       (m_tuser),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready)
	);
endmodule

[sim/tb_point_light_pixel_shader.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point light pixel shader testbench
// Loads the light table over the input stream and shades rays across several
// register settings. A scoreboard predicts every pixel beat in fixed point and
// compares it with the output stream, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_point_light_pixel_shader;
	import plps_pkg::*;

	localparam int          LIMIT_CYCLES = 6000000;
	localparam longint      SHADE_CAP    = 64'hFFFF_FFFF;

	typedef struct {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        hit;
	} pixel_t;

	class shade_scoreboard;
		pixel_t      pixels[$];
		logic [47:0] ambient, miss;
		logic [4:0]  count;
		logic [47:0] pos[LIGHT_SLOTS], col[LIGHT_SLOTS];
		logic [15:0] rng[LIGHT_SLOTS], inten[LIGHT_SLOTS];
		int          errors, shaded, lit, writes;

		function new();
			ambient = 0;
			miss    = MISS_RESET;
			count   = 0;
		endfunction

		function longint lane(logic [47:0] v, int k);
			return longint'($signed(v[16*k +: 16]));
		endfunction

		function void set_reg(logic [1:0] idx, logic [47:0] val);
			case (idx)
				CFG_AMBIENT: ambient = val;
				CFG_COUNT:   count   = val[4:0];
				CFG_MISS:    miss    = val;
				default: ;
			endcase
		endfunction

		function void note(logic mode, logic [215:0] d);
			pixel_t px;
			longint acc[3], p[3], l[3], m2, dot, f;
			int     n;
			logic [3:0]  slot;
			logic [1:0]  fld;
			logic [47:0] val, org, dir, nrm;
			logic [15:0] hit_dist;
			slot = d[164:161];
			fld  = d[166:165];
			val  = d[214:167];
			org  = d[48:1];
			dir  = d[96:49];
			hit_dist = d[112:97];
			nrm  = d[160:113];
			if (mode) begin
				writes++;
				case (fld)
					FLD_POS:   pos[slot]   = val;
					FLD_COLOR: col[slot]   = val;
					FLD_RANGE: rng[slot]   = val[15:0];
					default:   inten[slot] = val[15:0];
				endcase
				return;
			end
			shaded++;
			if (!d[0]) begin
				px = '{miss[15:0], miss[31:16], miss[47:32], 1'b0};
				pixels.push_back(px);
				return;
			end
			lit++;
			for (int k = 0; k < 3; k++) begin
				acc[k] = lane(ambient, k);
				p[k]   = lane(org, k) + ((lane(dir, k) * longint'(hit_dist)) >>> FRAC_BITS);
			end
			n = (count < LIGHT_SLOTS) ? count : LIGHT_SLOTS;
			for (int i = 0; i < n; i++) begin
				m2  = 0;
				dot = 0;
				for (int k = 0; k < 3; k++) begin
					l[k] = lane(pos[i], k) - p[k];
					m2  += l[k] * l[k];
					dot += lane(nrm, k) * l[k];
				end
				if (m2 > longint'(rng[i]) * longint'(rng[i]) || dot > 0)
					continue;
				if (m2 == 0)
					f = SHADE_CAP;
				else begin
					f = (longint'(inten[i]) << (2 * FRAC_BITS)) / m2;
					if (f > SHADE_CAP)
						f = SHADE_CAP;
				end
				for (int k = 0; k < 3; k++)
					acc[k] += (f * lane(col[i], k)) >>> FRAC_BITS;
			end
			for (int k = 0; k < 3; k++) begin
				if (acc[k] < 0)
					acc[k] = 0;
				if (acc[k] > 65535)
					acc[k] = 65535;
			end
			px = '{acc[0][15:0], acc[1][15:0], acc[2][15:0], 1'b1};
			pixels.push_back(px);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check(logic [47:0] rgb, logic hit);
			pixel_t e;
			if (pixels.size() == 0) begin
				report($sformatf("unexpected pixel %h", rgb));
				return;
			end
			e = pixels.pop_front();
			if (rgb[15:0] !== e.red)
				report($sformatf("red %h, want %h", rgb[15:0], e.red));
			if (rgb[31:16] !== e.green)
				report($sformatf("green %h, want %h", rgb[31:16], e.green));
			if (rgb[47:32] !== e.blue)
				report($sformatf("blue %h, want %h", rgb[47:32], e.blue));
			if (hit !== e.hit)
				report($sformatf("was_hit %b, want %b", hit, e.hit));
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [215:0] s_tdata = '0;
	logic         s_tuser = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [47:0]  m_tdata;
	logic         m_tuser;
	logic         cfg_we = 0;
	logic [1:0]   cfg_index = CFG_AMBIENT;
	logic [47:0]  cfg_wdata = '0;

	shade_scoreboard sb = new();
	int stall_mode, gap_max, burst_left, cycles;

	point_light_pixel_shader uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			2: m_tready <= (cycles % 7) < 3;
			default: m_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata, m_tuser);

	function automatic logic [15:0] near_lane();
		return 16'($urandom_range(0, 4095) - 2048);
	endfunction

	function automatic logic [47:0] near_vec();
		return {near_lane(), near_lane(), near_lane()};
	endfunction

	function automatic logic [47:0] wide_rand();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [215:0] ray_beat(logic hit, logic [47:0] org, logic [47:0] dir,
			logic [15:0] hit_dist, logic [47:0] nrm);
		logic [215:0] d;
		d = '0;
		d[0]       = hit;
		d[48:1]    = org;
		d[96:49]   = dir;
		d[112:97]  = hit_dist;
		d[160:113] = nrm;
		return d;
	endfunction

	function automatic logic [215:0] light_beat(logic [3:0] slot, logic [1:0] fld,
			logic [47:0] val);
		logic [215:0] d;
		d = '0;
		d[164:161] = slot;
		d[166:165] = fld;
		d[214:167] = val;
		return d;
	endfunction

	task send(logic mode, logic [215:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		sb.note(mode, d);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [47:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task send_light(logic [3:0] slot, bit wide);
		logic [1:0] fld;
		logic [47:0] val;
		fld = 2'($urandom_range(0, 3));
		if (wide || fld == FLD_COLOR)
			val = wide_rand();
		else if (fld == FLD_POS)
			val = near_vec();
		else
			val = {32'($urandom), 16'($urandom)};
		send(1'b1, light_beat(slot, fld, val));
	endtask

	task send_ray();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			send(1'b0, ray_beat(1'($urandom), wide_rand(), wide_rand(), 16'($urandom),
				wide_rand()));
		else
			send(1'b0, ray_beat(r != 2, near_vec(), near_vec(), 16'($urandom_range(0, 1024)),
				near_vec()));
	endtask

	initial begin
		int counts[8] = '{1, 3, 16, 2, 31, 5, 0, 4};
		int items;
		stall_mode = 0;
		gap_max = 0;
		burst_left = 0;
		cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(1'b0, ray_beat(1'b0, '1, '1, '1, '1));
		send(1'b0, ray_beat(1'b1, '0, '0, '0, '0));
		for (int s = 0; s < LIGHT_SLOTS; s++) begin
			send(1'b1, light_beat(4'(s), FLD_POS, near_vec()));
			send(1'b1, light_beat(4'(s), FLD_COLOR, wide_rand()));
			send(1'b1, light_beat(4'(s), FLD_RANGE, {32'hFFFF_FFFF, 16'hFFFF}));
			send(1'b1, light_beat(4'(s), FLD_INT, 48'h0));
		end
		send(1'b1, light_beat(4'd0, FLD_POS, {16'h0300, 16'hFE00, 16'h0100}));
		send(1'b1, light_beat(4'd0, FLD_COLOR, {16'h8000, 16'h7FFF, 16'h0100}));
		send(1'b1, light_beat(4'd0, FLD_RANGE, 48'h0));
		send(1'b1, light_beat(4'd0, FLD_INT, 48'hFFFF));
		drain();
		write_reg(CFG_AMBIENT, {16'h0040, 16'hFFFF, 16'h7FFF});
		write_reg(CFG_COUNT, 48'd1);
		write_reg(CFG_MISS, '1);
		send(1'b0, ray_beat(1'b1, {16'h0300, 16'hFE00, 16'h0100}, '1, 16'h0, '1));
		send(1'b0, ray_beat(1'b1, '0, '0, '0, '0));
		send(1'b0, ray_beat(1'b0, '0, '0, '0, '0));
		send(1'b1, light_beat(4'd0, FLD_RANGE, 48'hFFFF));
		send(1'b0, ray_beat(1'b1, {16'h0300, 16'hFE00, 16'h0100}, '0, 16'hFFFF, '0));
		send(1'b0, ray_beat(1'b1, {16'h0200, 16'hFE00, 16'h0100}, '0, 16'h0, '0));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			stall_mode = ph % 4;
			gap_max = (ph % 3 == 0) ? 0 : 6;
			write_reg(CFG_AMBIENT, (ph == 2) ? '0 : ((ph == 5) ? '1 : wide_rand()));
			write_reg(CFG_COUNT, 48'(counts[ph]));
			write_reg(CFG_MISS, (ph == 3) ? '0 : wide_rand());
			items = (counts[ph] >= 16) ? 80 : 250;
			for (int i = 0; i < items; i++) begin
				if ($urandom_range(0, 3) == 0)
					send_light(4'($urandom_range(0, 15)), $urandom_range(0, 4) == 0);
				else
					send_ray();
			end
			drain();
		end

		$display("Shaded %0d pixels (%0d hits) with %0d light table beats,",
			sb.shaded, sb.lit, sb.writes);
		$display("over eight register settings including zero and oversized light counts.");
		if (sb.errors == 0 && sb.pixels.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

[point_light_pixel_shader.f]
+incdir+rtl
rtl/plps_pkg.sv
rtl/plps_dp.sv
rtl/plps_ctrl.sv
rtl/point_light_pixel_shader.sv
sim/tb_point_light_pixel_shader.sv
